/* rtl/pcmng_pkg.sv */
package pcmng_pkg;

  localparam int PACKET_SAMPLES = 64;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  // stored count runs 0..PACKET_SAMPLES
  localparam int CNT_W  = $clog2(PACKET_SAMPLES + 1);
  localparam int ADDR_W = (PACKET_SAMPLES > 1) ? $clog2(PACKET_SAMPLES) : 1;
  // sum of PACKET_SAMPLES magnitudes of at most 32768
  localparam int SUM_W  = $clog2(PACKET_SAMPLES * 32768 + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALVE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE  = 2'd3;

  localparam logic [CFG_W-1:0] MUTE_RESET  = 16'd1500;
  localparam logic [CFG_W-1:0] HALVE_RESET = 16'd5000;
  localparam logic [CFG_W-1:0] VOICE_RESET = 16'd2500;

  typedef struct packed {
    logic [7:0] high_byte;
    logic [7:0] low_byte;
    logic       bad_frame;
    logic       last_pair;
  } pcmng_pair_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEVEL_W-1:0]         level;
    logic                       voice_present;
    logic                       last_sample;
  } pcmng_result_t;

endpackage

/* rtl/pcmng_pair_if.sv */
interface pcmng_pair_if import pcmng_pkg::*; ();
  logic        valid;
  logic        ready;
  pcmng_pair_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

/* rtl/pcmng_result_if.sv */
interface pcmng_result_if import pcmng_pkg::*; ();
  logic          valid;
  logic          ready;
  pcmng_result_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

/* rtl/pcm_packet_noise_gate_core.sv */
// Voice packet noise gate.
//
// pair_in takes one big-endian byte pair per beat; last_pair closes the
// packet and bad_frame on any pair spoils it. Each pair is blended into a
// signed sample, written to a 64-entry sample RAM and its magnitude added to
// a running sum, one pair per cycle. Pairs beyond the packet depth are
// dropped; packets that are bad or arrive while disabled produce nothing.
// After the last pair of a good packet the mean level is found by a
// bit-serial divider (one quotient bit per cycle), the gate thresholds are
// compared in the S_FLAGS state, then the RAM is read back through a
// registered read port and result_out gives one beat per cycle while the
// receiver is ready.
// pair_in.ready is low from the last pair until every result of the packet
// has moved into the output register; the final result may still wait there
// while the next packet streams in. A stall on result_out holds the read
// pipeline and the output register in place.
// The cfg port writes enable and the three thresholds by index. Reset
// clears enable, restores the default thresholds and empties the packet.
module pcm_packet_noise_gate_core import pcmng_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  pcmng_pair_if.sink           pair_in,
  pcmng_result_if.source       result_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [1:0] S_COLLECT = 2'd0;
  localparam logic [1:0] S_DIVIDE  = 2'd1;
  localparam logic [1:0] S_FLAGS   = 2'd2;
  localparam logic [1:0] S_DRAIN   = 2'd3;

  localparam int DIVC_W = $clog2(SUM_W);
  localparam logic [DIVC_W-1:0] DIV_LAST = DIVC_W'(SUM_W - 1);
  localparam logic [CNT_W-1:0]  DEPTH    = CNT_W'(PACKET_SAMPLES);

  // configuration
  logic             enable;
  logic [CFG_W-1:0] mute_below;
  logic [CFG_W-1:0] halve_below;
  logic [CFG_W-1:0] voice_at_least;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      mute_below     <= MUTE_RESET;
      halve_below    <= HALVE_RESET;
      voice_at_least <= VOICE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: enable         <= cfg_data[0];
        CFG_MUTE:   mute_below     <= cfg_data;
        CFG_HALVE:  halve_below    <= cfg_data;
        CFG_VOICE:  voice_at_least <= cfg_data;
        default:    ;
      endcase
    end
  end

  logic [1:0]        state;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  abs_sum;
  logic              packet_bad;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [DIVC_W-1:0] div_cnt;
  logic [LEVEL_W-1:0] level;
  logic              mute_f;
  logic              halve_f;
  logic              voice_f;
  logic [CNT_W-1:0]  rd_idx;
  logic              rd_valid;
  logic              rd_last;
  logic signed [SAMPLE_W-1:0] rdata;
  logic              out_valid;
  pcmng_result_t     out_data;

  logic signed [SAMPLE_W-1:0] sample_store [PACKET_SAMPLES];

  // pair blend: (3 * hi * 256 + full) / 4, truncated toward zero
  logic signed [SAMPLE_W-1:0] full_s;
  logic signed [SAMPLE_W-1:0] coarse_s;
  logic signed [SAMPLE_W+2:0] blend_sum;
  logic signed [SAMPLE_W+2:0] blend_adj;
  logic signed [SAMPLE_W-1:0] blend_s;
  logic [SAMPLE_W-1:0]        blend_abs;

  always_comb begin
    full_s    = {pair_in.payload.high_byte, pair_in.payload.low_byte};
    coarse_s  = {pair_in.payload.high_byte, 8'd0};
    blend_sum = (SAMPLE_W+3)'(coarse_s) + ((SAMPLE_W+3)'(coarse_s) <<< 1)
                + (SAMPLE_W+3)'(full_s);
    blend_adj = blend_sum[SAMPLE_W+2] ? blend_sum + (SAMPLE_W+3)'(3) : blend_sum;
    blend_s   = blend_adj[SAMPLE_W+1:2];
    blend_abs = blend_s[SAMPLE_W-1] ? (~blend_s + SAMPLE_W'(1)) : blend_s;
  end

  logic             accept;
  logic             bad_now;
  logic             store;
  logic [CNT_W-1:0] count_after;
  logic [SUM_W-1:0] sum_after;

  assign pair_in.ready = (state == S_COLLECT);
  assign accept      = pair_in.valid && pair_in.ready;
  assign bad_now     = packet_bad || pair_in.payload.bad_frame || !enable;
  assign store       = accept && !bad_now && (count < DEPTH);
  assign count_after = store ? count + CNT_W'(1) : count;
  assign sum_after   = store ? abs_sum + SUM_W'(blend_abs) : abs_sum;

  // restoring divider step
  logic [CNT_W:0] trial;
  logic           ge;
  logic [CNT_W:0] trial_sub;

  always_comb begin
    trial     = {rem, quo[SUM_W-1]};
    ge        = (trial >= {1'b0, count});
    trial_sub = trial - {1'b0, count};
  end

  logic advance;
  logic rd_en;
  logic drain_done;

  assign advance    = !out_valid || result_out.ready;
  assign rd_en      = (state == S_DRAIN) && advance && (rd_idx < count);
  assign drain_done = (state == S_DRAIN) && (rd_idx == count) && !rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      count      <= '0;
      abs_sum    <= '0;
      packet_bad <= 1'b0;
      div_cnt    <= '0;
      rd_idx     <= '0;
    end else begin
      case (state)
        S_COLLECT: begin
          if (accept) begin
            if (pair_in.payload.last_pair) begin
              if (bad_now || count_after == '0) begin
                count      <= '0;
                abs_sum    <= '0;
                packet_bad <= 1'b0;
              end else begin
                count   <= count_after;
                abs_sum <= sum_after;
                div_cnt <= '0;
                state   <= S_DIVIDE;
              end
            end else begin
              count      <= count_after;
              abs_sum    <= sum_after;
              packet_bad <= bad_now;
            end
          end
        end
        S_DIVIDE: begin
          div_cnt <= div_cnt + DIVC_W'(1);
          if (div_cnt == DIV_LAST) state <= S_FLAGS;
        end
        S_FLAGS: begin
          rd_idx <= '0;
          state  <= S_DRAIN;
        end
        S_DRAIN: begin
          if (rd_en) rd_idx <= rd_idx + CNT_W'(1);
          if (drain_done) begin
            count      <= '0;
            abs_sum    <= '0;
            packet_bad <= 1'b0;
            state      <= S_COLLECT;
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  // divider datapath and gate decision
  always_ff @(posedge clk) begin
    if (state == S_COLLECT) begin
      quo <= sum_after;
      rem <= '0;
    end else if (state == S_DIVIDE) begin
      quo <= {quo[SUM_W-2:0], ge};
      rem <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
    if (state == S_FLAGS) begin
      level   <= quo[LEVEL_W-1:0];
      mute_f  <= (quo[LEVEL_W-1:0] < mute_below);
      halve_f <= (quo[LEVEL_W-1:0] < halve_below);
      voice_f <= (quo[LEVEL_W-1:0] >= voice_at_least);
    end
  end

  // sample RAM: written while collecting, read while draining
  always_ff @(posedge clk) begin
    if (store) sample_store[count[ADDR_W-1:0]] <= blend_s;
    if (rd_en) rdata <= sample_store[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (advance) begin
      rd_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_last <= (rd_idx == count - CNT_W'(1));
  end

  logic signed [SAMPLE_W-1:0] gated;

  always_comb begin
    if (mute_f) begin
      gated = '0;
    end else if (halve_f) begin
      gated = (rdata + $signed({{(SAMPLE_W-1){1'b0}}, rdata[SAMPLE_W-1]})) >>> 1;
    end else begin
      gated = rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rd_valid) begin
      out_data.sample        <= gated;
      out_data.level         <= level;
      out_data.voice_present <= voice_f;
      out_data.last_sample   <= rd_last;
    end
  end

  assign result_out.valid   = out_valid;
  assign result_out.payload = out_data;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH)
    else $error("stored count above packet depth");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (count != '0))
    else $error("divide started with empty packet");

  a_no_input_in_readout: assert property (@(posedge clk) disable iff (rst)
    accept |-> !rd_valid)
    else $error("pair taken while readout in flight");

  a_read_only_draining: assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> (state == S_DRAIN))
    else $error("read data pending outside readout");

  a_last_closes_packet: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.ready && result_out.payload.last_sample)
      |-> !rd_valid)
    else $error("final result left entries unread");

endmodule
